>>> hdl/dbscan_pkg.sv
// Package for the point clusterer: sizes, state codes and the result record.
// No dependencies; used by every module in hdl.
package dbscan_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned QueueDepth = 4;

  localparam logic [0:0] RegEps = 1'b0;
  localparam logic [0:0] RegMinNb = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StSeedChk,
    StSeedRd,
    StSeedCnt,
    StExpand,
    StScanQueue,
    StPopChk,
    StPopRd,
    StPopEmit,
    StPopCnt,
    StNone,
    StFlush,
    StClear
  } core_state_e;

  // One result travelling from the cluster engine to the output stage.
  typedef struct packed {
    logic [6:0]           cluster_number;
    logic [5:0]           point_index;
    logic [CoordBits-1:0] out_x;
    logic [CoordBits-1:0] out_y;
    logic                 none_found;
    logic                 last_of_run;
  } result_t;

endpackage

>>> hdl/dbscan_point_clusterer.sv
// Top level of the DBSCAN point clusterer: config registers, engine, result queue.
// Depends on dbscan_pkg, dbscan_engine and dbscan_out.
//
//  channel  | handshake           | payload
//  input    | start, busy         | point_x_i, point_y_i, last_point_i
//  result   | result_valid_o      | cluster_number_o, point_index_o, out_x_o, out_y_o,
//           |                     | none_found_o, last_of_run_o
//  config   | cfg_we_i            | cfg_index_i, cfg_data_i
//
// A point without the last mark is stored at its accepting edge and busy stays
// low, so such points can follow back to back. The last point starts the run:
// each loaded point gets one neighbour scan plus its bookkeeping states, and
// each core point a second scan that queues its neighbours; the distance
// pipeline tests one pair per cycle. busy is high until the last result has
// left the queue. Results leave one per cycle and the receiver cannot stall;
// the engine waits only while the queue is full. Reset clears all marks at once.
module dbscan_point_clusterer #(
  parameter int unsigned MaxPoints = dbscan_pkg::MaxPoints
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] point_x_i,
  input  logic [15:0] point_y_i,
  input  logic        last_point_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [6:0]  cluster_number_o,
  output logic [5:0]  point_index_o,
  output logic [15:0] out_x_o,
  output logic [15:0] out_y_o,
  output logic        none_found_o,
  output logic        last_of_run_o
);
  logic [15:0] eps_q;
  logic [6:0] min_nb_q;
  logic accept, eng_busy, rv, full, empty;
  dbscan_pkg::result_t r, q;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= '0;
      min_nb_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == dbscan_pkg::RegEps) eps_q <= cfg_data_i;
      else min_nb_q <= cfg_data_i[6:0];
    end
  end

  assign busy = eng_busy || !empty;
  assign accept = start && !busy;

  dbscan_engine #(.MaxPoints(MaxPoints)) u_eng (
    .clk_i, .rst_ni,
    .load_i(accept),
    .x_i(point_x_i),
    .y_i(point_y_i),
    .run_i(accept && last_point_i),
    .eps_i(eps_q),
    .min_nb_i(min_nb_q),
    .busy_o(eng_busy),
    .res_valid_o(rv),
    .res_o(r),
    .res_full_i(full)
  );

  dbscan_out u_out (
    .clk_i, .rst_ni,
    .wr_i(rv), .wdata_i(r), .full_o(full), .empty_o(empty),
    .valid_o(result_valid_o), .rdata_o(q)
  );

  assign cluster_number_o = q.cluster_number;
  assign point_index_o = q.point_index;
  assign out_x_o = q.out_x;
  assign out_y_o = q.out_y;
  assign none_found_o = q.none_found;
  assign last_of_run_o = q.last_of_run;
endmodule

>>> hdl/dbscan_engine.sv
// Cluster engine: point store, mark vectors, expansion queue and the DBSCAN
// sequencer. One neighbour test per cycle. Depends on dbscan_pkg.
module dbscan_engine #(
  parameter int unsigned MaxPoints = dbscan_pkg::MaxPoints
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic [dbscan_pkg::CoordBits-1:0] x_i,
  input  logic [dbscan_pkg::CoordBits-1:0] y_i,
  input  logic                             run_i,
  input  logic [15:0]                      eps_i,
  input  logic [6:0]                       min_nb_i,
  output logic                             busy_o,
  output logic                             res_valid_o,
  output dbscan_pkg::result_t              res_o,
  input  logic                             res_full_i
);
  localparam int unsigned CW = dbscan_pkg::CoordBits;
  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned SqW = 2 * CW + 1;

  logic [CW-1:0] xs_q [MaxPoints];
  logic [CW-1:0] ys_q [MaxPoints];
  logic [IdxW-1:0] queue_q [MaxPoints];
  logic [MaxPoints-1:0] vis_q, clu_q, qd_q;
  logic [CntW-1:0] loaded_q, head_q, tail_q, j_q, nbc_q, outc_q, i_q;
  logic [6:0] cid_q;
  logic [IdxW-1:0] p_q, qhead_q, i_idx, j_idx;
  logic need_cnt_q;
  dbscan_pkg::core_state_e st_q, st_d;

  // Registered store reads: center point and scan point.
  logic [CW-1:0] px_q, py_q, jx_q, jy_q;
  logic [IdxW-1:0] jrd_q;
  logic jrd_v_q;
  logic [2*CW-1:0] e2_q;

  // Pipelined distance test: absolute differences, then squares, then compare.
  logic [CW-1:0] dx_q, dy_q;
  logic [IdxW-1:0] s1_idx_q, s2_idx_q;
  logic s1_v_q, s2_v_q;
  logic [2*CW-1:0] dx2_q, dy2_q;
  logic s2_nz_q;
  logic near;
  assign near = s2_v_q && s2_nz_q &&
                (SqW'(dx2_q) + SqW'(dy2_q) <= SqW'(e2_q));

  logic scan_active, scan_issue, scan_done, is_core, do_push;
  assign scan_active = (st_q == dbscan_pkg::StSeedCnt) || (st_q == dbscan_pkg::StPopCnt)
                    || (st_q == dbscan_pkg::StExpand);
  assign scan_issue = scan_active && (j_q < loaded_q);
  assign scan_done = scan_active && (j_q >= loaded_q) && !jrd_v_q && !s1_v_q && !s2_v_q;
  assign is_core = 8'(nbc_q) >= {1'b0, min_nb_i};
  assign i_idx = i_q[IdxW-1:0];
  assign j_idx = j_q[IdxW-1:0];

  // Point store, its two read ports and the distance pipeline.
  always_ff @(posedge clk_i) begin
    if (load_i && loaded_q < CntW'(MaxPoints)) begin
      xs_q[loaded_q[IdxW-1:0]] <= x_i;
      ys_q[loaded_q[IdxW-1:0]] <= y_i;
    end
    if (st_q == dbscan_pkg::StSeedRd || st_q == dbscan_pkg::StPopRd) begin
      px_q <= xs_q[p_q];
      py_q <= ys_q[p_q];
    end
    if (scan_issue) begin
      jx_q <= xs_q[j_idx];
      jy_q <= ys_q[j_idx];
      jrd_q <= j_idx;
    end
    dx_q <= (px_q > jx_q) ? px_q - jx_q : jx_q - px_q;
    dy_q <= (py_q > jy_q) ? py_q - jy_q : jy_q - py_q;
    s1_idx_q <= jrd_q;
    dx2_q <= (2*CW)'(dx_q) * (2*CW)'(dx_q);
    dy2_q <= (2*CW)'(dy_q) * (2*CW)'(dy_q);
    s2_nz_q <= (dx_q != '0) || (dy_q != '0);
    s2_idx_q <= s1_idx_q;
    e2_q <= (2*CW)'(eps_i) * (2*CW)'(eps_i);
  end

  // Queue store, written where the scan appends and read one entry per pop.
  assign do_push = (st_q == dbscan_pkg::StExpand) && near && !qd_q[s2_idx_q]
                && tail_q < CntW'(MaxPoints);
  always_ff @(posedge clk_i) begin
    if (do_push) queue_q[tail_q[IdxW-1:0]] <= s2_idx_q;
    if (st_q == dbscan_pkg::StScanQueue && head_q < tail_q) begin
      qhead_q <= queue_q[head_q[IdxW-1:0]];
    end
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      dbscan_pkg::StIdle: if (run_i) st_d = dbscan_pkg::StSeedChk;
      dbscan_pkg::StSeedChk: begin
        if (i_q >= loaded_q) st_d = (outc_q == '0) ? dbscan_pkg::StNone
                                                   : dbscan_pkg::StFlush;
        else if (!vis_q[i_idx]) st_d = dbscan_pkg::StSeedRd;
      end
      dbscan_pkg::StSeedRd: st_d = dbscan_pkg::StSeedCnt;
      dbscan_pkg::StSeedCnt: if (scan_done) begin
        if (!is_core) st_d = dbscan_pkg::StSeedChk;
        else if (!res_full_i) st_d = dbscan_pkg::StExpand;
      end
      dbscan_pkg::StExpand: if (scan_done) st_d = dbscan_pkg::StScanQueue;
      dbscan_pkg::StScanQueue: st_d = (head_q < tail_q) ? dbscan_pkg::StPopChk
                                                        : dbscan_pkg::StSeedChk;
      dbscan_pkg::StPopChk: st_d = dbscan_pkg::StPopRd;
      dbscan_pkg::StPopRd: st_d = dbscan_pkg::StPopEmit;
      dbscan_pkg::StPopEmit: if (!res_full_i) st_d = need_cnt_q ? dbscan_pkg::StPopCnt
                                                                : dbscan_pkg::StScanQueue;
      dbscan_pkg::StPopCnt: if (scan_done) st_d = is_core ? dbscan_pkg::StExpand
                                                          : dbscan_pkg::StScanQueue;
      dbscan_pkg::StNone: if (!res_full_i) st_d = dbscan_pkg::StClear;
      dbscan_pkg::StFlush: if (!res_full_i) st_d = dbscan_pkg::StClear;
      dbscan_pkg::StClear: st_d = dbscan_pkg::StIdle;
      default: st_d = dbscan_pkg::StIdle;
    endcase
  end

  // Held back result so last_of_run can be set on the final one.
  dbscan_pkg::result_t hold_q;
  logic hold_v_q;
  logic emit;
  dbscan_pkg::result_t emit_r;

  // A new core seed, or a popped point that is not yet in a cluster, is emitted.
  always_comb begin
    emit = 1'b0;
    emit_r = '0;
    emit_r.cluster_number = cid_q;
    emit_r.point_index = 6'(p_q);
    emit_r.out_x = px_q;
    emit_r.out_y = py_q;
    if (st_q == dbscan_pkg::StSeedCnt && scan_done && is_core && !res_full_i) begin
      emit = 1'b1;
      emit_r.cluster_number = cid_q + 7'd1;
    end else if (st_q == dbscan_pkg::StPopEmit && !res_full_i && !clu_q[p_q]
                 && outc_q < CntW'(MaxPoints)) begin
      emit = 1'b1;
    end
  end

  // Outputs toward the result stage.
  always_comb begin
    res_valid_o = 1'b0;
    res_o = hold_q;
    unique case (st_q)
      dbscan_pkg::StNone: begin
        res_valid_o = !res_full_i;
        res_o = '0;
        res_o.none_found = 1'b1;
        res_o.last_of_run = 1'b1;
      end
      dbscan_pkg::StFlush: begin
        res_valid_o = hold_v_q && !res_full_i;
        res_o.last_of_run = 1'b1;
      end
      default: res_valid_o = hold_v_q && emit;
    endcase
  end
  assign busy_o = (st_q != dbscan_pkg::StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dbscan_pkg::StIdle;
      vis_q <= '0;
      clu_q <= '0;
      qd_q <= '0;
      loaded_q <= '0;
      cid_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      j_q <= '0;
      nbc_q <= '0;
      outc_q <= '0;
      i_q <= '0;
      p_q <= '0;
      need_cnt_q <= 1'b0;
      jrd_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      hold_v_q <= 1'b0;
      hold_q <= '0;
    end else begin
      st_q <= st_d;
      jrd_v_q <= scan_issue;
      s1_v_q <= jrd_v_q;
      s2_v_q <= s1_v_q;
      if (load_i && loaded_q < CntW'(MaxPoints)) loaded_q <= loaded_q + 1'b1;
      // The scan index restarts whenever a scan is entered anew.
      if (!scan_active || (scan_done && st_d != st_q)) j_q <= '0;
      else if (scan_issue) j_q <= j_q + 1'b1;
      if (!scan_active) nbc_q <= '0;
      else if (near && st_q != dbscan_pkg::StExpand) nbc_q <= nbc_q + 1'b1;
      if (do_push) begin
        qd_q[s2_idx_q] <= 1'b1;
        tail_q <= tail_q + 1'b1;
      end
      if (emit) begin
        hold_q <= emit_r;
        hold_v_q <= 1'b1;
        outc_q <= outc_q + 1'b1;
      end
      case (st_q)
        dbscan_pkg::StIdle: begin
          i_q <= '0;
          outc_q <= '0;
        end
        dbscan_pkg::StSeedChk: begin
          if (i_q < loaded_q) begin
            if (vis_q[i_idx]) i_q <= i_q + 1'b1;
            else begin
              vis_q[i_idx] <= 1'b1;
              p_q <= i_idx;
            end
          end
        end
        dbscan_pkg::StSeedCnt: if (scan_done) begin
          if (!is_core) i_q <= i_q + 1'b1;
          else if (!res_full_i) begin
            cid_q <= cid_q + 1'b1;
            clu_q[p_q] <= 1'b1;
            qd_q[p_q] <= 1'b1;
            head_q <= '0;
            tail_q <= '0;
          end
        end
        dbscan_pkg::StScanQueue: begin
          if (head_q < tail_q) head_q <= head_q + 1'b1;
          else i_q <= i_q + 1'b1;
        end
        dbscan_pkg::StPopChk: begin
          p_q <= qhead_q;
          need_cnt_q <= !vis_q[qhead_q];
          vis_q[qhead_q] <= 1'b1;
        end
        dbscan_pkg::StPopEmit: if (emit) clu_q[p_q] <= 1'b1;
        dbscan_pkg::StClear: begin
          vis_q <= '0;
          clu_q <= '0;
          qd_q <= '0;
          loaded_q <= '0;
          cid_q <= '0;
          hold_v_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Each index is queued at most once per run, so the queue never overruns.
  assert property (@(posedge clk_i) disable iff (!rst_ni) tail_q <= CntW'(MaxPoints))
    else $error("expansion queue overran");
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= tail_q)
    else $error("queue head passed its tail");
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid_o |-> !res_full_i)
    else $error("result sent while the result queue was full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> st_q == dbscan_pkg::StIdle)
    else $error("point loaded during a run");
endmodule

>>> hdl/dbscan_out.sv
// Result stage: short queue between the engine and the strobed result ports.
// Depends on dbscan_pkg.
module dbscan_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  dbscan_pkg::result_t wdata_i,
  output logic                full_o,
  output logic                empty_o,
  output logic                valid_o,
  output dbscan_pkg::result_t rdata_o
);
  localparam int unsigned D = dbscan_pkg::QueueDepth;
  localparam int unsigned AW = $clog2(D);
  dbscan_pkg::result_t mem_q [D];
  logic [AW:0] wp_q, rp_q;
  logic rd;
  assign empty_o = (wp_q == rp_q);
  assign full_o = (wp_q[AW-1:0] == rp_q[AW-1:0]) && (wp_q[AW] != rp_q[AW]);
  assign rd = !empty_o;

  // One result leaves the queue every cycle it holds one.
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q[AW-1:0]] <= wdata_i;
    if (rd) rdata_o <= mem_q[rp_q[AW-1:0]];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      valid_o <= 1'b0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      valid_o <= rd;
    end
  end
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i |-> !full_o)
    else $error("result queue written while full");
endmodule
